// ----- rtl/pnh_pkg.sv -----
// ----------------------------------------------------------------------------
// pnh_pkg
// Shared types and codes for the page navigation block: command and result
// words, operation and status codes, recent-list size.
// ----------------------------------------------------------------------------
package pnh_pkg;

	localparam int NAV_DEPTH_DEF = 16;
	localparam int RECENT_SLOTS  = 5;

	// operation codes
	localparam logic [1:0] KIND_OPEN = 2'd0;
	localparam logic [1:0] KIND_FWD  = 2'd1;
	localparam logic [1:0] KIND_BACK = 2'd2;

	// status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_NEXT = 2'd1;
	localparam logic [1:0] STATUS_NO_PREV = 2'd2;
	localparam logic [1:0] STATUS_NO_PAGE = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] page_name;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic       has_page;
		logic [7:0] current_page;
		logic [2:0] recent_count;
		logic [7:0] recent_0;
		logic [7:0] recent_1;
		logic [7:0] recent_2;
		logic [7:0] recent_3;
		logic [7:0] recent_4;
	} res_word_t;

	// navigation outcome handed from the pointer unit to the top level
	typedef struct packed {
		logic [1:0] status;
		logic       has_page;
		logic       wr_en;
	} nav_res_t;

endpackage

// ----- rtl/pnh_ram.sv -----
// ----------------------------------------------------------------------------
// pnh_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pnh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/pnh_nav.sv -----
// ----------------------------------------------------------------------------
// pnh_nav
// History pointers: oldest slot, length and position of the ring. Computes
// the post-command position and its ring address for the history RAM.
// ----------------------------------------------------------------------------
module pnh_nav import pnh_pkg::*; #(
	parameter int NAV_DEPTH = NAV_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [1:0]                   kind,
	output logic [$clog2(NAV_DEPTH)-1:0] addr,
	output nav_res_t                     res
);

	localparam int PW = $clog2(NAV_DEPTH);
	localparam int LW = $clog2(NAV_DEPTH + 1);
	localparam logic [PW-1:0] LAST_POS = PW'(NAV_DEPTH - 1);

	logic [PW-1:0] oldest_q, oldest_d;
	logic [LW-1:0] len_q, len_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [PW:0]   sum;

	always_comb begin
		oldest_d   = oldest_q;
		len_d      = len_q;
		pos_d      = pos_q;
		res.status = STATUS_OK;
		res.wr_en  = 1'b0;
		case (kind)
			KIND_OPEN: begin
				res.wr_en = 1'b1;
				if (len_q == '0) begin
					len_d = LW'(1);
					pos_d = '0;
				end else if (pos_q == LAST_POS) begin
					// ring full: drop the oldest entry
					oldest_d = (oldest_q == LAST_POS) ? '0 : oldest_q + PW'(1);
					len_d    = LW'(NAV_DEPTH);
					pos_d    = LAST_POS;
				end else begin
					pos_d = pos_q + PW'(1);
					len_d = LW'(pos_q) + LW'(2);
				end
			end
			KIND_FWD: begin
				if (len_q == '0) begin
					res.status = STATUS_NO_PAGE;
				end else if (LW'(pos_q) + LW'(1) >= len_q) begin
					res.status = STATUS_NO_NEXT;
				end else begin
					pos_d = pos_q + PW'(1);
				end
			end
			KIND_BACK: begin
				if (len_q == '0) begin
					res.status = STATUS_NO_PAGE;
				end else if (pos_q == '0) begin
					res.status = STATUS_NO_PREV;
				end else begin
					pos_d = pos_q - PW'(1);
				end
			end
			default: begin
			end
		endcase
		res.has_page = (len_d != '0);
		// ring index: sum stays below twice the depth
		sum = {1'b0, oldest_d} + {1'b0, pos_d};
		if (sum >= (PW+1)'(NAV_DEPTH)) begin
			sum = sum - (PW+1)'(NAV_DEPTH);
		end
		addr = sum[PW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			len_q    <= '0;
			pos_q    <= '0;
		end else if (accept) begin
			oldest_q <= oldest_d;
			len_q    <= len_d;
			pos_q    <= pos_d;
		end
	end

endmodule

// ----- rtl/pnh_recent.sv -----
// ----------------------------------------------------------------------------
// pnh_recent
// Five-entry recent list in recency order, oldest first. Presents the list
// as it stands after the current command.
// ----------------------------------------------------------------------------
module pnh_recent import pnh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       touch,
	input  logic [7:0] name,
	output logic [2:0] count,
	output logic [7:0] view [RECENT_SLOTS]
);

	logic [7:0] rec_q [RECENT_SLOTS];
	logic [7:0] rec_d [RECENT_SLOTS];
	logic [2:0] used_q, used_d;
	logic [RECENT_SLOTS-1:0] match, past_hit;

	always_comb begin
		for (int i = 0; i < RECENT_SLOTS; i++) begin
			match[i] = (3'(i) < used_q) && (rec_q[i] == name);
		end
		// at or after the hit slot
		past_hit[0] = match[0];
		for (int i = 1; i < RECENT_SLOTS; i++) begin
			past_hit[i] = past_hit[i-1] | match[i];
		end

		rec_d  = rec_q;
		used_d = used_q;
		if (touch) begin
			if (|match) begin
				// move hit to newest slot, close the gap
				for (int i = 0; i < RECENT_SLOTS; i++) begin
					if (3'(i) == used_q - 3'd1) begin
						rec_d[i] = name;
					end else if (past_hit[i] && (3'(i) < used_q) && (i < RECENT_SLOTS - 1)) begin
						rec_d[i] = rec_q[(i < RECENT_SLOTS - 1) ? i + 1 : i];
					end
				end
			end else if (used_q == 3'(RECENT_SLOTS)) begin
				// evict oldest
				for (int i = 0; i < RECENT_SLOTS - 1; i++) begin
					rec_d[i] = rec_q[i+1];
				end
				rec_d[RECENT_SLOTS-1] = name;
			end else begin
				for (int i = 0; i < RECENT_SLOTS; i++) begin
					if (3'(i) == used_q) begin
						rec_d[i] = name;
					end
				end
				used_d = used_q + 3'd1;
			end
		end

		count = used_d;
		for (int i = 0; i < RECENT_SLOTS; i++) begin
			view[i] = (3'(i) < used_d) ? rec_d[i] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int i = 0; i < RECENT_SLOTS; i++) begin
				rec_q[i] <= '0;
			end
		end else if (accept) begin
			used_q <= used_d;
			rec_q  <= rec_d;
		end
	end

endmodule

// ----- rtl/page_navigation_with_recent_history.sv -----
// ----------------------------------------------------------------------------
// page_navigation_with_recent_history
// Back/forward page history kept in a RAM ring, plus a five-entry recent
// list. One result word per command word.
// ----------------------------------------------------------------------------
//   channel | signals                        | carries
//   --------+--------------------------------+-------------------------------
//   cmd     | cmd_valid, cmd_ready, cmd      | kind, page_name
//   res     | res_valid, res_ready, res      | status, current page, recents
//
// Takes one word per clock while the result side is not stalled. A command
// passes through the stage-1 register, alongside the registered read of the
// history RAM, and then through the result register.
// Reset empties the history and the recent list at once; history RAM
// entries are only read after being written, so no clearing pass.
// While res_ready is low, the stage-1 register and the result register hold
// up to two words before cmd_ready drops.
// ----------------------------------------------------------------------------
module page_navigation_with_recent_history import pnh_pkg::*; #(
	parameter int NAV_DEPTH = NAV_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_word_t cmd,
	output logic      res_valid,
	input  logic      res_ready,
	output res_word_t res
);

	localparam int PW = $clog2(NAV_DEPTH);

	logic          accept;
	logic          advance;
	logic [PW-1:0] hist_addr;
	nav_res_t      nav;
	logic [7:0]    hist_rdata;
	logic [2:0]    rec_count;
	logic [7:0]    rec_view [RECENT_SLOTS];

	// stage 1: command done, waiting on the RAM read
	logic       v_s1;
	logic       open_s1;
	logic [7:0] name_s1;
	logic [1:0] status_s1;
	logic       has_s1;
	logic [2:0] count_s1;
	logic [7:0] rec_s1 [RECENT_SLOTS];

	logic res_valid_q;
	res_word_t res_q;

	// result register frees when empty or being taken
	assign advance   = !res_valid_q || res_ready;
	assign cmd_ready = !v_s1 || advance;
	assign accept    = cmd_valid && cmd_ready;

	pnh_nav #(
		.NAV_DEPTH(NAV_DEPTH)
	) u_nav (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.kind  (cmd.kind),
		.addr  (hist_addr),
		.res   (nav)
	);

	// Write on open goes to the new current slot; read the current slot
	// after every command. Same-address write and read only happen on open,
	// where the name is forwarded instead of the read data.
	pnh_ram #(
		.WIDTH(8),
		.DEPTH(NAV_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (accept && nav.wr_en),
		.waddr(hist_addr),
		.wdata(cmd.page_name),
		.re   (accept),
		.raddr(hist_addr),
		.rdata(hist_rdata)
	);

	pnh_recent u_recent (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.touch (nav.wr_en),
		.name  (cmd.page_name),
		.count (rec_count),
		.view  (rec_view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			open_s1   <= nav.wr_en;
			name_s1   <= cmd.page_name;
			status_s1 <= nav.status;
			has_s1    <= nav.has_page;
			count_s1  <= rec_count;
			rec_s1    <= rec_view;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			res_q.status       <= status_s1;
			res_q.has_page     <= has_s1;
			res_q.current_page <= !has_s1 ? 8'd0 : (open_s1 ? name_s1 : hist_rdata);
			res_q.recent_count <= count_s1;
			res_q.recent_0     <= rec_s1[0];
			res_q.recent_1     <= rec_s1[1];
			res_q.recent_2     <= rec_s1[2];
			res_q.recent_3     <= rec_s1[3];
			res_q.recent_4     <= rec_s1[4];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- rtl/pnh_checker.sv -----
// ----------------------------------------------------------------------------
// pnh_checker
// Port-level checks for the page navigation block, bound to the top level.
// ----------------------------------------------------------------------------
module pnh_checker import pnh_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_ready,
	input logic      res_valid,
	input logic      res_ready,
	input res_word_t res
);

	// stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	// commands are only refused when both buffer stages are full and stalled
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> res_valid && !res_ready)
		else $error("cmd_ready low without output backpressure");

	// no current page means empty name; no-page status only without a page
	a_no_page: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.has_page |-> res.current_page == 8'd0)
		else $error("current page set without a page");

	a_status_page: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == STATUS_NO_PAGE |-> !res.has_page)
		else $error("no-page status with a page present");

	// recent list never exceeds its slots; an open always leaves an entry
	a_recent_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.recent_count <= 3'(RECENT_SLOTS)
			&& (res.has_page == (res.recent_count != 3'd0)))
		else $error("recent count inconsistent");

endmodule

bind page_navigation_with_recent_history pnh_checker u_pnh_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for page_navigation_with_recent_history. A queue of
// command words (directed corner cases, then bursts of opens and back/forward
// walks) feeds a clocked driver. Each accepted command runs through a local
// model of the history ring and recent list. A clocked monitor checks every
// result word against the oldest prediction. Idling on both sides runs in
// three traffic phases.
// ----------------------------------------------------------------------------
module testbench;
	import pnh_pkg::*;

	// kind value the block leaves unused: no state change, status ok
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam int RANDOM_ITEMS = 650;
	localparam int STALL_LIMIT  = 4000;	// cycles with no word moving on either side
	localparam int DRAIN_CYCLES = 10;	// two-stage pipe, plus margin

	// traffic phases: who idles
	localparam int PH_SLOW_SINK = 0;	// sender idles 17%, receiver 85%
	localparam int PH_SLOW_SRC  = 1;	// sender idles 85%, receiver 17%
	localparam int PH_FULL_RATE = 2;	// nobody idles

	typedef struct {
		cmd_word_t word;
		int        phase;
	} cmd_item_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_word_t cmd       = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	res_word_t res;

	page_navigation_with_recent_history u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Local model state: history ring, position, recent (MRU) list
	// ------------------------------------------------------------------
	logic [7:0] hist_pages [NAV_DEPTH_DEF];
	int         hist_oldest = 0;
	int         hist_len    = 0;
	int         hist_pos    = 0;
	logic [7:0] mru_pages [RECENT_SLOTS] = '{default: 8'h00};
	int         mru_used    = 0;

	cmd_item_t  pending_cmds [$];
	res_word_t  expected_views [$];
	int         traffic_phase = PH_SLOW_SINK;

	int items_total;
	int results_seen;
	int mismatches;
	int stall_cycles;

	// coverage-ish tallies for the closing summary
	int kind_tally [4];
	int status_tally [4];
	int ring_drops;
	int recent_hits;
	int recent_evicts;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch, result word %0d: %s", $time, results_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(input string fname, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", fname, got, want));
	endtask

	// Applies one accepted command to the model and queues the view the
	// block must report for it.
	task automatic predict_view(input cmd_word_t c);
		res_word_t  v;
		logic [1:0] st;
		int         hit;
		int         i;
		st = STATUS_OK;
		kind_tally[c.kind]++;
		case (c.kind)
		KIND_OPEN: begin
			// forward entries are dropped by setting length just past position
			if (hist_len == 0) begin
				hist_len = 1;
				hist_pos = 0;
			end else if (hist_pos + 2 > NAV_DEPTH_DEF) begin
				// ring full at the top: oldest entry falls off
				hist_oldest = (hist_oldest + 1) % NAV_DEPTH_DEF;
				hist_len    = NAV_DEPTH_DEF;
				hist_pos    = NAV_DEPTH_DEF - 1;
				ring_drops++;
			end else begin
				hist_pos = hist_pos + 1;
				hist_len = hist_pos + 1;
			end
			hist_pages[(hist_oldest + hist_pos) % NAV_DEPTH_DEF] = c.page_name;

			// recent list: hit moves to newest, miss appends or evicts oldest
			hit = -1;
			for (i = 0; i < mru_used; i++)
				if (hit < 0 && mru_pages[i] == c.page_name)
					hit = i;
			if (hit >= 0) begin
				for (i = hit; i + 1 < mru_used; i++)
					mru_pages[i] = mru_pages[i + 1];
				mru_pages[mru_used - 1] = c.page_name;
				recent_hits++;
			end else if (mru_used == RECENT_SLOTS) begin
				for (i = 0; i + 1 < RECENT_SLOTS; i++)
					mru_pages[i] = mru_pages[i + 1];
				mru_pages[RECENT_SLOTS - 1] = c.page_name;
				recent_evicts++;
			end else begin
				mru_pages[mru_used] = c.page_name;
				mru_used++;
			end
		end
		KIND_FWD: begin
			if (hist_len == 0)
				st = STATUS_NO_PAGE;
			else if (hist_pos + 1 >= hist_len)
				st = STATUS_NO_NEXT;
			else
				hist_pos++;
		end
		KIND_BACK: begin
			if (hist_len == 0)
				st = STATUS_NO_PAGE;
			else if (hist_pos == 0)
				st = STATUS_NO_PREV;
			else
				hist_pos--;
		end
		default: ;	// unused kind: nothing moves
		endcase
		status_tally[st]++;

		v.status       = st;
		v.has_page     = (hist_len != 0);
		v.current_page = (hist_len != 0) ?
			hist_pages[(hist_oldest + hist_pos) % NAV_DEPTH_DEF] : 8'h00;
		v.recent_count = 3'(mru_used);
		v.recent_0     = (mru_used > 0) ? mru_pages[0] : 8'h00;
		v.recent_1     = (mru_used > 1) ? mru_pages[1] : 8'h00;
		v.recent_2     = (mru_used > 2) ? mru_pages[2] : 8'h00;
		v.recent_3     = (mru_used > 3) ? mru_pages[3] : 8'h00;
		v.recent_4     = (mru_used > 4) ? mru_pages[4] : 8'h00;
		expected_views.push_back(v);
	endtask

	// ------------------------------------------------------------------
	// Driver: launches the next pending word once the current one is taken.
	// Prediction happens at the accepting edge, so expectations always lead
	// the matching result.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : cmd_driver
		cmd_item_t nxt;
		bit        hold;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd       <= '0;
		end else begin
			if (cmd_valid && cmd_ready)
				predict_view(cmd);
			if (!cmd_valid || cmd_ready) begin
				hold = 1'b0;
				if (pending_cmds.size() > 0) begin
					case (pending_cmds[0].phase)
					PH_SLOW_SINK: hold = ($urandom_range(0, 99) < 17);
					PH_SLOW_SRC:  hold = ($urandom_range(0, 99) < 85);
					default:      hold = 1'b0;
					endcase
				end
				if (pending_cmds.size() > 0 && !hold) begin
					nxt = pending_cmds.pop_front();
					cmd_valid     <= 1'b1;
					cmd           <= nxt.word;
					traffic_phase <= nxt.phase;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each taken result word field by field, then picks
	// the next ready level from the current traffic phase.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : res_monitor
		res_word_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_views.size() == 0) begin
					report_mismatch("result word with nothing outstanding");
				end else begin
					want = expected_views.pop_front();
					check_field("status",       8'(res.status),       8'(want.status));
					check_field("has_page",     8'(res.has_page),     8'(want.has_page));
					check_field("current_page", res.current_page,     want.current_page);
					check_field("recent_count", 8'(res.recent_count), 8'(want.recent_count));
					check_field("recent_0",     res.recent_0,         want.recent_0);
					check_field("recent_1",     res.recent_1,         want.recent_1);
					check_field("recent_2",     res.recent_2,         want.recent_2);
					check_field("recent_3",     res.recent_3,         want.recent_3);
					check_field("recent_4",     res.recent_4,         want.recent_4);
				end
				results_seen++;
			end
			case (traffic_phase)
			PH_SLOW_SINK: res_ready <= ($urandom_range(0, 99) >= 85);
			PH_SLOW_SRC:  res_ready <= ($urandom_range(0, 99) >= 17);
			default:      res_ready <= 1'b1;
			endcase
		end
	end

	// Watchdog: a hung handshake ends the run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[%0t] no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	logic [7:0] name_pool [7] = '{8'h00, 8'h01, 8'h5A, 8'h7F, 8'h80, 8'hFE, 8'hFF};

	task automatic push_cmd(input logic [1:0] k, input logic [7:0] n);
		cmd_item_t it;
		it.word.kind      = k;
		it.word.page_name = n;
		it.phase          = PH_SLOW_SINK;
		pending_cmds.push_back(it);
	endtask

	// mostly a small pool so the recent list sees hits; sometimes any byte
	function automatic logic [7:0] pick_name();
		if ($urandom_range(0, 99) < 65)
			return name_pool[$urandom_range(0, 6)];
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		int n_rand;
		int mode;
		int burst;
		int j;

		// -- directed --
		// nothing open yet: both moves report no page, unused kind is harmless
		push_cmd(KIND_FWD,  8'hFF);
		push_cmd(KIND_BACK, 8'hFF);
		push_cmd(KIND_NONE, 8'hA5);
		// extremes of the name, then reopen the current page
		push_cmd(KIND_OPEN, 8'h00);
		push_cmd(KIND_OPEN, 8'hFF);
		push_cmd(KIND_OPEN, 8'hFF);
		// walk back past the oldest entry, then forward past the newest
		push_cmd(KIND_BACK, 8'h00);
		push_cmd(KIND_BACK, 8'h00);
		push_cmd(KIND_BACK, 8'h00);
		push_cmd(KIND_FWD,  8'h00);
		push_cmd(KIND_FWD,  8'h00);
		push_cmd(KIND_FWD,  8'h00);
		// fill the recent list, evict, then hit an entry in the middle
		push_cmd(KIND_OPEN, 8'h55);
		push_cmd(KIND_OPEN, 8'hAA);
		push_cmd(KIND_OPEN, 8'h01);
		push_cmd(KIND_OPEN, 8'h80);
		push_cmd(KIND_OPEN, 8'h55);
		// open after going back truncates the forward entries
		push_cmd(KIND_BACK, 8'h00);
		push_cmd(KIND_BACK, 8'h00);
		push_cmd(KIND_OPEN, 8'h7F);
		push_cmd(KIND_FWD,  8'h00);
		push_cmd(KIND_NONE, 8'h5A);

		// -- random bursts --
		// long open runs push the ring past its depth; walks exercise the
		// position; a few noise bursts throw in every kind.
		n_rand = 0;
		while (n_rand < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 9);
			if (mode == 0)
				burst = $urandom_range(12, 24);
			else
				burst = $urandom_range(1, 8);
			for (j = 0; j < burst; j++) begin
				if (mode <= 4)
					push_cmd(KIND_OPEN, pick_name());
				else if (mode <= 8)
					push_cmd($urandom_range(0, 1) ? KIND_BACK : KIND_FWD,
						8'($urandom_range(0, 255)));
				else
					push_cmd(2'($urandom_range(0, 3)), pick_name());
			end
			n_rand += burst;
		end

		// split the run into the three traffic phases
		items_total = pending_cmds.size();
		foreach (pending_cmds[i])
			pending_cmds[i].phase = (i * 3) / items_total;

		// -- reset, once --
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// one result word per command word
		while (results_seen < items_total)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_views.size() != 0)
			report_mismatch($sformatf("%0d predictions never answered",
				expected_views.size()));

		$display("covered %0d command words: %0d open, %0d forward, %0d back, %0d unused kind",
			items_total, kind_tally[KIND_OPEN], kind_tally[KIND_FWD],
			kind_tally[KIND_BACK], kind_tally[KIND_NONE]);
		$display("ring drops %0d, recent hits %0d, evictions %0d, status ok/next/prev/none %0d/%0d/%0d/%0d",
			ring_drops, recent_hits, recent_evicts, status_tally[STATUS_OK],
			status_tally[STATUS_NO_NEXT], status_tally[STATUS_NO_PREV],
			status_tally[STATUS_NO_PAGE]);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
